// ===== rtl/smtp_data_dot_unstuffer_top_defines.svh =====
// ----------------------------------------------------------------------------
// SMTP dot unstuffer assertion macros
// Shared concurrent assertion forms for the unstuffer modules.
// ----------------------------------------------------------------------------
`ifndef SMTP_DATA_DOT_UNSTUFFER_TOP_DEFINES_SVH
`define SMTP_DATA_DOT_UNSTUFFER_TOP_DEFINES_SVH

// property holds at every edge out of reset
`define SMTPDU_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define SMTPDU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SMTPDU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/smtpdu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP dot unstuffer package
// Character codes, window size and the op and queue status types shared by the blocks.
// ----------------------------------------------------------------------------
package smtpdu_pkg;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_DOT = 8'h2E;

   localparam int WIN_DEPTH = 5;
   localparam int FILL_W    = 3;

   typedef enum logic {
      OP_BYTE,
      OP_FINISH
   } op_kind_type;

   // grp marks work that belongs to the end-of-body item
   typedef struct packed {
      op_kind_type kind;
      logic        grp;
      logic [7:0]  data;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/smtpdu_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP dot unstuffer input channel
// Valid/ready channel carrying one raw body byte per word.
// ----------------------------------------------------------------------------
interface smtpdu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_body;

   modport source (output valid, data_byte, byte_present, end_of_body, input ready);
   modport sink   (input valid, data_byte, byte_present, end_of_body, output ready);
endinterface

// ===== rtl/smtpdu_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP dot unstuffer result channel
// Valid/ready channel carrying one unstuffed body byte per word.
// ----------------------------------------------------------------------------
interface smtpdu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_present;
   logic       out_last;

   modport source (output valid, out_byte, out_present, out_last, input ready);
   modport sink   (input valid, out_byte, out_present, out_last, output ready);
endinterface

// ===== rtl/smtpdu_opq.sv =====
`timescale 1ns / 1ps
`include "smtp_data_dot_unstuffer_top_defines.svh"
// ----------------------------------------------------------------------------
// SMTP dot unstuffer op queue
// Small register FIFO between the window front end and the line back end.
// ----------------------------------------------------------------------------
module smtpdu_opq
   import smtpdu_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  op_type       push_op,
   input  logic         pop,
   output op_type       head_op,
   output q_status_type q_st
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type          mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign do_push = push && (count_ff != CW'(DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   assign head_op    = mem_ff[rd_ptr_ff];
   assign q_st.full  = (count_ff == CW'(DEPTH));
   assign q_st.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   `SMTPDU_ASSERT_IMPL(a_no_push_full, clock, reset, count_ff == CW'(DEPTH), !push, "op queue overflow")
   `SMTPDU_ASSERT_IMPL(a_no_pop_empty, clock, reset, count_ff == '0, !pop, "op queue underflow")
   `SMTPDU_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CW'(DEPTH), "op count out of range")

endmodule

// ===== rtl/smtpdu_front.sv =====
`timescale 1ns / 1ps
`include "smtp_data_dot_unstuffer_top_defines.svh"
// ----------------------------------------------------------------------------
// SMTP dot unstuffer front end
// Holds the newest five bytes, strips the terminator at end of body and
// issues byte and finish ops to the queue.
// ----------------------------------------------------------------------------
module smtpdu_front
   import smtpdu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   smtpdu_req_if.sink   req,
   input  q_status_type q_st,
   output logic         push,
   output op_type       push_op
);

   logic [WIN_DEPTH-1:0][7:0] win_ff, win_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [FILL_W-1:0]         drain_cnt_ff, drain_cnt_in;
   logic                      drain_ff, drain_in;
   logic                      fire;

   function automatic logic is_dot_crlf(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      return (a == CH_DOT) && (b == CH_CR) && (c == CH_LF);
   endfunction

   // number of window bytes that survive terminator removal
   function automatic logic [FILL_W-1:0] keep_of(input logic [WIN_DEPTH-1:0][7:0] w,
                                                 input logic [FILL_W-1:0] f);
      logic full_term;
      logic short_term;
      full_term = (f == FILL_W'(WIN_DEPTH)) && (w[0] == CH_CR) && (w[1] == CH_LF) &&
                  is_dot_crlf(w[2], w[3], w[4]);
      unique case (f)
         3'd3:    short_term = is_dot_crlf(w[0], w[1], w[2]);
         3'd4:    short_term = is_dot_crlf(w[1], w[2], w[3]);
         3'd5:    short_term = is_dot_crlf(w[2], w[3], w[4]);
         default: short_term = 1'b0;
      endcase
      if (full_term) begin
         return '0;
      end else if (short_term) begin
         return f - 3'd3;
      end
      return f;
   endfunction

   assign req.ready = !drain_ff && !q_st.full;
   assign fire      = req.valid && req.ready;

   always_comb begin
      win_in       = win_ff;
      fill_in      = fill_ff;
      drain_in     = drain_ff;
      drain_cnt_in = drain_cnt_ff;
      push         = 1'b0;
      push_op      = '{kind: OP_BYTE, grp: req.end_of_body, data: win_ff[0]};
      if (drain_ff) begin
         // flush surviving bytes oldest first, then close the body
         if (!q_st.full) begin
            push        = 1'b1;
            push_op.grp = 1'b1;
            if (drain_cnt_ff != '0) begin
               for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                  win_in[i] = win_ff[i + 1];
               end
               drain_cnt_in = drain_cnt_ff - 1'b1;
            end else begin
               push_op.kind = OP_FINISH;
               drain_in     = 1'b0;
               fill_in      = '0;
            end
         end
      end else if (fire) begin
         if (req.byte_present) begin
            if (fill_ff == FILL_W'(WIN_DEPTH)) begin
               push = 1'b1;
               for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                  win_in[i] = win_ff[i + 1];
               end
               win_in[WIN_DEPTH - 1] = req.data_byte;
            end else begin
               for (int i = 0; i < WIN_DEPTH; i++) begin
                  if (fill_ff == FILL_W'(i)) begin
                     win_in[i] = req.data_byte;
                  end
               end
               fill_in = fill_ff + 1'b1;
            end
         end
         if (req.end_of_body) begin
            drain_in     = 1'b1;
            drain_cnt_in = keep_of(win_in, fill_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         drain_ff     <= 1'b0;
         drain_cnt_ff <= '0;
      end else begin
         fill_ff      <= fill_in;
         drain_ff     <= drain_in;
         drain_cnt_ff <= drain_cnt_in;
      end
      win_ff <= win_in;
   end

   `SMTPDU_ASSERT_ALWAYS(a_fill_range, clock, reset, fill_ff <= FILL_W'(WIN_DEPTH), "window fill out of range")
   `SMTPDU_ASSERT_NEXT(a_finish_clears, clock, reset, push && (push_op.kind == OP_FINISH), (fill_ff == '0) && !drain_ff, "window not cleared after finish")
   `SMTPDU_ASSERT_IMPL(a_drain_bound, clock, reset, drain_ff, drain_cnt_ff <= fill_ff, "drain count exceeds window fill")

endmodule

// ===== rtl/smtpdu_back.sv =====
`timescale 1ns / 1ps
`include "smtp_data_dot_unstuffer_top_defines.svh"
// ----------------------------------------------------------------------------
// SMTP dot unstuffer back end
// Line stage: splits at LF, drops one CR before LF or end, unstuffs leading
// dots and appends CRLF. One word is held back so the last can be flagged.
// ----------------------------------------------------------------------------
module smtpdu_back
   import smtpdu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  op_type       head_op,
   input  q_status_type q_st,
   output logic         pop,
   smtpdu_rsp_if.source rsp
);

   typedef enum logic [1:0] {
      LP_START,
      LP_DOT,
      LP_BODY
   } line_pos_type;

   typedef struct packed {
      logic [7:0] data;
      logic       grp;
   } word_type;

   line_pos_type    prog_ff, prog_in, prog_nx;
   logic            held_cr_ff, held_cr_in, held_nx;
   logic [1:0]      step_ff, step_in;
   logic            closing_ff, closing_in;
   logic            pend_v_ff, pend_v_in;
   word_type        pend_ff, pend_in;
   logic            out_v_ff, out_v_in;
   logic [7:0]      out_byte_ff, out_byte_in;
   logic            out_present_ff, out_present_in;
   logic            out_last_ff, out_last_in;

   logic [2:0][7:0] w_list;
   logic [1:0]      n_words;
   logic            emit_c;
   logic            out_free, can_push, advance, last_step;

   // words produced by the op at the head of the queue
   always_comb begin
      w_list  = '0;
      n_words = '0;
      prog_nx = prog_ff;
      held_nx = held_cr_ff;
      emit_c  = 1'b0;
      if (head_op.kind == OP_FINISH) begin
         if (prog_ff != LP_START) begin
            if (prog_ff == LP_DOT) begin
               w_list[n_words] = CH_DOT;
               n_words         = n_words + 2'd1;
            end
            w_list[n_words] = CH_CR;
            n_words         = n_words + 2'd1;
            w_list[n_words] = CH_LF;
            n_words         = n_words + 2'd1;
         end
      end else if (head_op.data == CH_LF) begin
         if (prog_ff == LP_DOT) begin
            w_list[n_words] = CH_DOT;
            n_words         = n_words + 2'd1;
         end
         w_list[n_words] = CH_CR;
         n_words         = n_words + 2'd1;
         w_list[n_words] = CH_LF;
         n_words         = n_words + 2'd1;
         prog_nx         = LP_START;
         held_nx         = 1'b0;
      end else begin
         emit_c = 1'b1;
         unique case (prog_ff)
            LP_START: begin
               if (head_op.data == CH_DOT) begin
                  prog_nx = LP_DOT;
                  emit_c  = 1'b0;
               end else begin
                  prog_nx = LP_BODY;
               end
            end
            LP_DOT: begin
               // second dot of a stuffed pair is dropped
               prog_nx         = LP_BODY;
               w_list[n_words] = CH_DOT;
               n_words         = n_words + 2'd1;
               if (head_op.data == CH_DOT) begin
                  emit_c = 1'b0;
               end
            end
            default: begin
               prog_nx = LP_BODY;
            end
         endcase
         if (emit_c) begin
            if (held_cr_ff) begin
               w_list[n_words] = CH_CR;
               n_words         = n_words + 2'd1;
               held_nx         = 1'b0;
            end
            if (head_op.data == CH_CR) begin
               held_nx = 1'b1;
            end else begin
               w_list[n_words] = head_op.data;
               n_words         = n_words + 2'd1;
            end
         end
      end
   end

   assign out_free  = !out_v_ff || rsp.ready;
   assign can_push  = !pend_v_ff || out_free;
   assign advance   = (n_words == '0) || can_push;
   assign last_step = (n_words == '0) || (step_ff == n_words - 2'd1);

   always_comb begin
      pop            = 1'b0;
      step_in        = step_ff;
      closing_in     = closing_ff;
      prog_in        = prog_ff;
      held_cr_in     = held_cr_ff;
      pend_v_in      = pend_v_ff;
      pend_in        = pend_ff;
      out_v_in       = out_v_ff && !rsp.ready;
      out_byte_in    = out_byte_ff;
      out_present_in = out_present_ff;
      out_last_in    = out_last_ff;
      if (!q_st.empty) begin
         if (closing_ff) begin
            // send the held word, flagged as last if it ends the body, or a bare end marker
            if (out_free) begin
               out_v_in = 1'b1;
               if (pend_v_ff) begin
                  out_byte_in    = pend_ff.data;
                  out_present_in = 1'b1;
                  out_last_in    = pend_ff.grp;
                  pend_v_in      = 1'b0;
               end else begin
                  out_byte_in    = '0;
                  out_present_in = 1'b0;
                  out_last_in    = 1'b1;
               end
               if (!pend_v_ff || pend_ff.grp) begin
                  pop        = 1'b1;
                  closing_in = 1'b0;
                  prog_in    = LP_START;
                  held_cr_in = 1'b0;
               end
            end
         end else if (advance) begin
            if (n_words != '0) begin
               if (pend_v_ff) begin
                  out_v_in       = 1'b1;
                  out_byte_in    = pend_ff.data;
                  out_present_in = 1'b1;
                  out_last_in    = 1'b0;
               end
               pend_v_in    = 1'b1;
               pend_in.data = w_list[step_ff];
               pend_in.grp  = head_op.grp;
            end
            if (last_step) begin
               step_in = '0;
               if (head_op.kind == OP_FINISH) begin
                  closing_in = 1'b1;
               end else begin
                  pop        = 1'b1;
                  prog_in    = prog_nx;
                  held_cr_in = held_nx;
               end
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_ff    <= LP_START;
         held_cr_ff <= 1'b0;
         step_ff    <= '0;
         closing_ff <= 1'b0;
         pend_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         prog_ff    <= prog_in;
         held_cr_ff <= held_cr_in;
         step_ff    <= step_in;
         closing_ff <= closing_in;
         pend_v_ff  <= pend_v_in;
         out_v_ff   <= out_v_in;
      end
      pend_ff        <= pend_in;
      out_byte_ff    <= out_byte_in;
      out_present_ff <= out_present_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp.valid       = out_v_ff;
   assign rsp.out_byte    = out_byte_ff;
   assign rsp.out_present = out_present_ff;
   assign rsp.out_last    = out_last_ff;

   `SMTPDU_ASSERT_IMPL(a_marker_form, clock, reset, out_v_ff && !out_present_ff, out_last_ff && (out_byte_ff == '0), "bare marker not last or nonzero")
   `SMTPDU_ASSERT_IMPL(a_closing_head, clock, reset, closing_ff, !q_st.empty && (head_op.kind == OP_FINISH), "closing without finish op")
   `SMTPDU_ASSERT_NEXT(a_close_drains, clock, reset, pop && (head_op.kind == OP_FINISH), !pend_v_ff && !closing_ff, "held word left after body end")

endmodule

// ===== rtl/smtp_data_dot_unstuffer_top.sv =====
`timescale 1ns / 1ps
// Path: a byte reaches the line stage once five newer bytes arrive or the body ends;
//   via the op queue and the held-word register it enters the output register when the next word follows.
// Throughput: 1 byte per cycle while the op queue has room; the back end emits up to 3 words for an LF.
// End of body blocks input while the kept window bytes and the finish op are issued, and longer
//   while the op queue is full.
// Reset: synchronous, active high; clears fill, line state, queue and output valid.
// ----------------------------------------------------------------------------
// SMTP DATA dot unstuffer
// Front window stage, op queue and line back end with a registered output.
// ----------------------------------------------------------------------------
module smtp_data_dot_unstuffer_top
   import smtpdu_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   smtpdu_req_if.sink   req_ch,
   smtpdu_rsp_if.source rsp_ch
);

   logic         push;
   logic         pop;
   op_type       push_op;
   op_type       head_op;
   q_status_type q_st;

   smtpdu_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .q_st    (q_st),
      .push    (push),
      .push_op (push_op)
   );

   smtpdu_opq #(
      .DEPTH (QUEUE_DEPTH)
   ) u_opq (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .q_st    (q_st)
   );

   smtpdu_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head_op (head_op),
      .q_st    (q_st),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

endmodule

// ===== test/tb_smtp_data_dot_unstuffer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP DATA dot unstuffer testbench
// Drives raw body bytes with random gaps and output stalls, predicts the
// unstuffed CRLF-normalized words in-line and checks every output word.
// ----------------------------------------------------------------------------
module tb_smtp_data_dot_unstuffer_top
   import smtpdu_pkg::*;
();

   localparam int ITEM_TARGET   = 200;
   localparam int CALM_ITEMS    = 40;
   localparam int MAX_WORDS     = 14;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 30;
   localparam int N_DIRECTED    = 25;

   typedef enum logic [1:0] {
      AT_LINE_START,
      DOT_HELD,
      IN_LINE
   } line_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       is_last;
   } unstuffed_word_type;

   typedef struct {
      logic [7:0]         data;
      logic               present;
      logic               eob;
      bit                 typed;
      unstuffed_word_type typed_word;
   } stim_row_type;

   localparam unstuffed_word_type NO_WORD = '{8'h00, 1'b0, 1'b0};

   logic clock;
   logic reset;

   smtpdu_req_if req_ch();
   smtpdu_rsp_if rsp_ch();

   smtp_data_dot_unstuffer_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // directed words; typed expectations only where they are obvious
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},   // empty body
      '{8'hA5, 1'b0, 1'b0, 1'b0, NO_WORD},                // ignored word
      '{8'h00, 1'b1, 1'b0, 1'b0, NO_WORD},
      '{8'hFF, 1'b1, 1'b0, 1'b0, NO_WORD},
      '{8'h41, 1'b1, 1'b0, 1'b0, NO_WORD},
      '{8'h42, 1'b1, 1'b0, 1'b0, NO_WORD},
      '{8'h43, 1'b1, 1'b0, 1'b0, NO_WORD},
      '{CH_CR, 1'b1, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},   // oldest byte leaves window
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_WORD},                // end, final piece w/o LF
      '{CH_DOT, 1'b1, 1'b0, 1'b0, NO_WORD},               // stuffed line
      '{CH_DOT, 1'b1, 1'b0, 1'b0, NO_WORD},
      '{8'h58, 1'b1, 1'b0, 1'b0, NO_WORD},
      '{CH_CR, 1'b1, 1'b0, 1'b0, NO_WORD},
      '{CH_LF, 1'b1, 1'b0, 1'b0, NO_WORD},
      '{CH_DOT, 1'b1, 1'b0, 1'b0, NO_WORD},               // full terminator
      '{CH_CR, 1'b1, 1'b0, 1'b0, NO_WORD},
      '{CH_LF, 1'b1, 1'b1, 1'b0, NO_WORD},
      '{CH_DOT, 1'b1, 1'b0, 1'b0, NO_WORD},               // short terminator only
      '{CH_CR, 1'b1, 1'b0, 1'b0, NO_WORD},
      '{CH_LF, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{8'h61, 1'b1, 1'b0, 1'b0, NO_WORD},                // trailing CR at end
      '{CH_CR, 1'b1, 1'b1, 1'b0, NO_WORD},
      '{CH_DOT, 1'b1, 1'b0, 1'b0, NO_WORD},               // lone dot line
      '{CH_LF, 1'b1, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_WORD}
   };

   // predictor state
   logic [7:0]     win [WIN_DEPTH];
   int             win_fill;
   line_state_type line_state;
   logic           cr_pending;

   unstuffed_word_type step_words [$];
   unstuffed_word_type pending_words [$];
   stim_row_type       body_rows [$];

   int mismatches;
   int items_sent;
   int quiet_cycles;
   int stall_left;
   bit calm;

   function automatic void put_word(logic [7:0] data, logic present);
      if (step_words.size() < MAX_WORDS)
         step_words.push_back('{data, present, 1'b0});
   endfunction

   function automatic void clear_unstuffer();
      foreach (win[i]) win[i] = 8'h00;
      win_fill   = 0;
      line_state = AT_LINE_START;
      cr_pending = 1'b0;
   endfunction

   function automatic void unstuff_byte(logic [7:0] c);
      if (c == CH_LF) begin
         if (line_state == DOT_HELD)
            put_word(CH_DOT, 1'b1);
         put_word(CH_CR, 1'b1);
         put_word(CH_LF, 1'b1);
         line_state = AT_LINE_START;
         cr_pending = 1'b0;
         return;
      end
      unique case (line_state)
         AT_LINE_START: begin
            if (c == CH_DOT) begin
               line_state = DOT_HELD;
               return;
            end
            line_state = IN_LINE;
         end
         DOT_HELD: begin
            line_state = IN_LINE;
            put_word(CH_DOT, 1'b1);
            if (c == CH_DOT)
               return;
         end
         default: line_state = IN_LINE;
      endcase
      if (cr_pending) begin
         put_word(CH_CR, 1'b1);
         cr_pending = 1'b0;
      end
      if (c == CH_CR)
         cr_pending = 1'b1;
      else
         put_word(c, 1'b1);
   endfunction

   function automatic void close_body();
      int keep;
      keep = win_fill;
      if (keep == WIN_DEPTH && win[0] == CH_CR && win[1] == CH_LF && win[2] == CH_DOT &&
          win[3] == CH_CR && win[4] == CH_LF) begin
         keep = 0;
      end else if (keep >= 3 && win[keep-3] == CH_DOT && win[keep-2] == CH_CR &&
                   win[keep-1] == CH_LF) begin
         keep -= 3;
      end
      for (int i = 0; i < keep; i++)
         unstuff_byte(win[i]);
      if (line_state != AT_LINE_START) begin
         if (line_state == DOT_HELD)
            put_word(CH_DOT, 1'b1);
         put_word(CH_CR, 1'b1);
         put_word(CH_LF, 1'b1);
      end
      if (step_words.size() == 0)
         put_word(8'h00, 1'b0);
      step_words[step_words.size()-1].is_last = 1'b1;
      clear_unstuffer();
   endfunction

   function automatic void predict_unstuffed(logic [7:0] data, logic present, logic eob);
      step_words.delete();
      if (present) begin
         if (win_fill >= WIN_DEPTH) begin
            unstuff_byte(win[0]);
            for (int i = 0; i < WIN_DEPTH - 1; i++)
               win[i] = win[i+1];
            win[WIN_DEPTH-1] = data;
         end else begin
            win[win_fill] = data;
            win_fill++;
         end
      end
      if (eob)
         close_body();
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(stim_row_type row);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.data_byte    <= row.data;
      req_ch.byte_present <= row.present;
      req_ch.end_of_body  <= row.eob;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_unstuffed(row.data, row.present, row.eob);
      if (row.typed)
         pending_words.push_back(row.typed_word);
      else
         foreach (step_words[i]) pending_words.push_back(step_words[i]);
      if (row.present || row.eob)
         items_sent++;
      if (items_sent >= ITEM_TARGET - CALM_ITEMS)
         calm = 1'b1;
      @(negedge clock);
   endtask

   function automatic void add_byte(logic [7:0] data);
      body_rows.push_back('{data, 1'b1, 1'b0, 1'b0, NO_WORD});
   endfunction

   function automatic logic [7:0] line_char();
      unique case ($urandom_range(0, 7))
         0:       return CH_DOT;
         1:       return CH_CR;
         2:       return 8'($urandom_range(128, 255));
         default: return 8'($urandom_range(8'h20, 8'h7E));
      endcase
   endfunction

   function automatic logic [7:0] noise_char();
      unique case ($urandom_range(0, 5))
         0:       return CH_CR;
         1:       return CH_LF;
         2:       return CH_DOT;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly well-formed bodies, some truncated, some noise, some empty
   task automatic send_random_body();
      int kind;
      kind = $urandom_range(0, 9);
      body_rows.delete();
      if (kind <= 6) begin
         repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 2) == 0) begin
               add_byte(CH_DOT);
               add_byte(CH_DOT);
            end
            repeat ($urandom_range(0, 5)) add_byte(line_char());
            add_byte(CH_CR);
            add_byte(CH_LF);
         end
         if (kind <= 5) begin
            add_byte(CH_DOT);
            add_byte(CH_CR);
            add_byte(CH_LF);
         end else begin
            unique case ($urandom_range(0, 2))
               0: begin
                  add_byte(CH_DOT);
                  add_byte(CH_CR);
               end
               1: add_byte(line_char());
               default: ;
            endcase
         end
      end else if (kind <= 8) begin
         repeat ($urandom_range(1, 12)) add_byte(noise_char());
      end
      if (body_rows.size() == 0 || $urandom_range(0, 3) == 0)
         body_rows.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_WORD});
      else
         body_rows[body_rows.size()-1].eob = 1'b1;
      foreach (body_rows[i]) begin
         if ($urandom_range(0, 11) == 0)
            send_word('{8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_WORD});
         send_word(body_rows[i]);
      end
   endtask

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = ~clock;
   end

   // output stalls in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left = $urandom_range(1, 13) - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // output check and watchdog
   always @(posedge clock) begin
      unstuffed_word_type exp_word;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected word: out_byte %02h out_present %0b out_last %0b",
                   rsp_ch.out_byte, rsp_ch.out_present, rsp_ch.out_last);
            mismatches++;
         end else begin
            exp_word = pending_words.pop_front();
            if (rsp_ch.out_byte !== exp_word.data) begin
               $error("out_byte: expected %02h, actual %02h", exp_word.data, rsp_ch.out_byte);
               mismatches++;
            end
            if (rsp_ch.out_present !== exp_word.present) begin
               $error("out_present: expected %0b, actual %0b",
                      exp_word.present, rsp_ch.out_present);
               mismatches++;
            end
            if (rsp_ch.out_last !== exp_word.is_last) begin
               $error("out_last: expected %0b, actual %0b", exp_word.is_last, rsp_ch.out_last);
               mismatches++;
            end
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.data_byte    = 8'h00;
      req_ch.byte_present = 1'b0;
      req_ch.end_of_body  = 1'b0;
      rsp_ch.ready        = 1'b0;
      mismatches          = 0;
      items_sent          = 0;
      quiet_cycles        = 0;
      stall_left          = 0;
      calm                = 1'b0;
      clear_unstuffer();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_DIRECTED; i++)
         send_word(directed_rows[i]);
      while (items_sent < ITEM_TARGET)
         send_random_body();
      req_ch.valid <= 1'b0;

      while (pending_words.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
